>>> hdl/ile_pkg.sv
// Package for the indexed list engine: beat structs, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package ile_pkg;
	localparam int CAPACITY_DEF = 256;

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_APPEND = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_PUT    = 3'd4;
	localparam logic [2:0] OP_INSERT = 3'd5;
	localparam logic [2:0] OP_DELETE = 3'd6;
	localparam logic [2:0] OP_CLEAR  = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic [8:0]         position;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [8:0]         length;
		logic               empty_res;
		logic [1:0]         status;
	} out_beat_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture the input beat, restart the walk
		logic step;      // advance the walk by one link
		logic rd1;       // read element and link at the cursor
		logic rd2;       // read the second link (free head or victim)
		logic finish;    // run the commit step and load result
	} ile_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic walk_done;  // cursor sits on the target slot
	} ile_sts_t;
endpackage

>>> hdl/ile_ctrl.sv
// Controller for the indexed list engine: sequences walk, read and commit.
// Depends on ile_pkg.
`timescale 1ns / 1ps
module ile_ctrl
	import ile_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     out_busy,
	input  ile_sts_t sts,
	output ile_cmd_t cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_RD1   = 3'd2;
	localparam logic [2:0] S_RD2   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.walk_done) state_d = S_RD1;
				else cmd.step = 1'b1;
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.rd2 = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> hdl/ile_dp.sv
// Datapath for the indexed list engine: element and link memories, list
// registers, walk cursor and result register. Depends on ile_pkg.
`timescale 1ns / 1ps
module ile_dp
	import ile_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_beat,
	input  ile_cmd_t  cmd,
	output ile_sts_t  sts,
	input  logic      out_stall,
	output logic      out_valid,
	output out_beat_t out_beat,
	output logic      out_busy
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = (CW > 9) ? CW : 9;

	logic signed [31:0] elem_mem [CAPACITY];
	logic [AW-1:0]      link_mem [CAPACITY];

	in_beat_t      cur_q;
	logic [AW-1:0] head_q, tail_q, free_head_q, cursor_q;
	logic [CW-1:0] count_q, free_cnt_q, fresh_q;
	logic [DW-1:0] walk_cnt_q;
	logic [AW-1:0] lrd_q, lnk1_q;
	logic signed [31:0] elem_rd_q;
	logic          lw2_pend_q;
	logic [AW-1:0] lw2_a_q, lw2_d_q;

	// Decode of the captured beat.
	logic [DW-1:0] pos_w, cnt_w;
	logic full, emp, pos_ge, pos_gt, pos0, pos_end, last;
	logic mid_ins, mid_del;
	assign pos_w   = DW'(cur_q.position);
	assign cnt_w   = DW'(count_q);
	assign full    = (count_q >= CW'(CAPACITY));
	assign emp     = (count_q == '0);
	assign pos_ge  = (pos_w >= cnt_w);
	assign pos_gt  = (pos_w > cnt_w);
	assign pos0    = (cur_q.position == '0);
	assign pos_end = (pos_w == cnt_w);
	assign last    = (pos_w == cnt_w - DW'(1));
	assign mid_ins = (cur_q.operation == OP_INSERT) && !pos_gt && !full && !pos0 && !pos_end;
	assign mid_del = (cur_q.operation == OP_DELETE) && !emp && !pos_ge && !pos0;

	// Walk target: position for get/put, position-1 for mid insert/delete.
	logic [DW-1:0] target;
	always_comb begin
		target = '0;
		unique case (cur_q.operation)
			OP_GET, OP_PUT: if (!pos_ge) target = pos_w;
			OP_INSERT: if (mid_ins) target = pos_w - DW'(1);
			OP_DELETE: if (mid_del) target = pos_w - DW'(1);
			default: target = '0;
		endcase
	end

	assign sts.walk_done = (walk_cnt_q == target);

	// Slot allocation.
	logic [AW-1:0] new_slot;
	logic          use_free;
	assign use_free = (free_cnt_q != '0);
	assign new_slot = use_free ? free_head_q : fresh_q[AW-1:0];

	// Capture the beat and count walk steps.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= in_beat;
			walk_cnt_q <= '0;
		end else if (cmd.step) begin
			walk_cnt_q <= walk_cnt_q + DW'(1);
		end
	end

	// Memory read ports, registered: one link address and one element address.
	logic [AW-1:0] cursor_c, lrd_addr;
	assign cursor_c = (walk_cnt_q == '0) ? head_q : lrd_q;
	assign lrd_addr = cmd.rd2 ? (mid_del ? lrd_q : free_head_q) : cursor_c;
	always_ff @(posedge clk) begin
		if (cmd.step || cmd.rd1 || cmd.rd2) lrd_q <= link_mem[lrd_addr];
		if (cmd.rd1) begin
			elem_rd_q <= elem_mem[cursor_c];
			cursor_q  <= cursor_c;
		end
		if (cmd.rd2) lnk1_q <= lrd_q;
	end

	// Commit: memory writes and status.
	logic          lw_en, ew_en;
	logic [AW-1:0] lw_a, ew_a;
	logic [AW-1:0] lw_d;
	logic          lw2_en;
	logic [AW-1:0] lw2_a, lw2_d;
	logic [1:0]    st;
	logic signed [31:0] rd_v;

	always_comb begin
		lw_en = 1'b0; lw_a = '0; lw_d = '0;
		lw2_en = 1'b0; lw2_a = '0; lw2_d = '0;
		ew_en = 1'b0; ew_a = new_slot;
		st = ST_OK; rd_v = '0;
		unique case (cur_q.operation)
			OP_PUSH: if (full) st = ST_FULL;
				else begin
					ew_en = 1'b1; lw_en = 1'b1; lw_a = new_slot; lw_d = head_q;
				end
			OP_POP: if (emp) st = ST_EMPTY;
				else begin
					rd_v = elem_rd_q; lw_en = 1'b1; lw_a = head_q; lw_d = free_head_q;
				end
			OP_APPEND: if (full) st = ST_FULL;
				else begin
					ew_en = 1'b1; lw_en = 1'b1; lw_a = new_slot; lw_d = '0;
					lw2_en = !emp; lw2_a = tail_q; lw2_d = new_slot;
				end
			OP_GET: if (pos_ge) st = ST_RANGE; else rd_v = elem_rd_q;
			OP_PUT: if (pos_ge) st = ST_RANGE;
				else begin
					ew_en = 1'b1; ew_a = cursor_q;
				end
			OP_INSERT: if (pos_gt) st = ST_RANGE;
				else if (full) st = ST_FULL;
				else begin
					ew_en = 1'b1; lw_en = 1'b1; lw_a = new_slot;
					if (pos0) lw_d = head_q;
					else if (pos_end) begin
						lw_d = '0; lw2_en = 1'b1; lw2_a = tail_q; lw2_d = new_slot;
					end else begin
						lw_d = lnk1_q; lw2_en = 1'b1; lw2_a = cursor_q; lw2_d = new_slot;
					end
				end
			OP_DELETE: if (emp) st = ST_EMPTY;
				else if (pos_ge) st = ST_RANGE;
				else if (pos0) begin
					lw_en = 1'b1; lw_a = head_q; lw_d = free_head_q;
				end else begin
					lw_en = 1'b1; lw_a = cursor_q; lw_d = lrd_q;
					lw2_en = 1'b1; lw2_a = lnk1_q; lw2_d = free_head_q;
				end
			default: st = ST_OK;
		endcase
	end

	// Write ports: the second link write of a commit is registered and goes out in the next cycle.
	logic          lwr_en;
	logic [AW-1:0] lwr_a, lwr_d;
	assign lwr_en = lw2_pend_q || (cmd.finish && lw_en);
	assign lwr_a  = lw2_pend_q ? lw2_a_q : lw_a;
	assign lwr_d  = lw2_pend_q ? lw2_d_q : lw_d;
	always_ff @(posedge clk) begin
		if (cmd.finish && ew_en) elem_mem[ew_a] <= cur_q.value;
		if (lwr_en) link_mem[lwr_a] <= lwr_d;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lw2_pend_q <= 1'b0;
		else lw2_pend_q <= cmd.finish && lw2_en;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			lw2_a_q <= lw2_a;
			lw2_d_q <= lw2_d;
		end
	end

	// List control registers.
	logic ok;
	assign ok = (st == ST_OK);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; free_head_q <= '0;
			count_q <= '0; free_cnt_q <= '0; fresh_q <= '0;
		end else if (cmd.finish && ok) begin
			unique case (cur_q.operation)
				OP_PUSH, OP_APPEND, OP_INSERT: begin
					if (use_free) begin
						free_head_q <= lrd_q;
						free_cnt_q  <= free_cnt_q - CW'(1);
					end else fresh_q <= fresh_q + CW'(1);
					count_q <= count_q + CW'(1);
					if (cur_q.operation == OP_PUSH ||
							(cur_q.operation == OP_INSERT && pos0)) begin
						head_q <= new_slot;
						if (emp) tail_q <= new_slot;
					end else if (cur_q.operation == OP_APPEND ||
							(cur_q.operation == OP_INSERT && pos_end)) begin
						if (emp) head_q <= new_slot;
						tail_q <= new_slot;
					end
				end
				OP_POP, OP_DELETE: begin
					count_q <= count_q - CW'(1);
					free_cnt_q <= free_cnt_q + CW'(1);
					if (cur_q.operation == OP_POP || pos0) begin
						free_head_q <= head_q;
						if (count_q == CW'(1)) begin
							head_q <= '0; tail_q <= '0;
						end else head_q <= lnk1_q;
					end else begin
						free_head_q <= lnk1_q;
						if (last) tail_q <= cursor_q;
					end
				end
				OP_CLEAR: begin
					head_q <= '0; tail_q <= '0; free_head_q <= '0;
					count_q <= '0; free_cnt_q <= '0; fresh_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Result register.
	logic [CW-1:0] len_n;
	always_comb begin
		len_n = count_q;
		if (ok) unique case (cur_q.operation)
			OP_PUSH, OP_APPEND, OP_INSERT: len_n = count_q + CW'(1);
			OP_POP, OP_DELETE: len_n = count_q - CW'(1);
			OP_CLEAR: len_n = '0;
			default: len_n = count_q;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.finish) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_beat.read_value <= rd_v;
			out_beat.length     <= 9'(len_n);
			out_beat.empty_res  <= (len_n == '0);
			out_beat.status     <= st;
		end
	end
	assign out_busy = out_valid && out_stall;
endmodule

>>> hdl/indexed_list_engine_unit.sv
// Indexed list engine: singly linked list of signed 32-bit values with free list.
// Each operation runs load, walk, two reads and commit; the walk hops position times
// (get/put) or position-1 times (mid insert/delete), others none.
// A new item is taken only once the last has committed; a stalled result holds commit.
// Reset (arst_n low) empties the list; memories need no clearing.
`timescale 1ns / 1ps
module indexed_list_engine_unit
	import ile_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);
	ile_cmd_t cmd;
	ile_sts_t sts;
	logic     out_busy;

	ile_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_busy(out_busy), .sts(sts), .cmd(cmd)
	);

	ile_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .cmd(cmd), .sts(sts),
		.out_stall(out_stall), .out_valid(out_valid), .out_beat(out_data),
		.out_busy(out_busy)
	);
endmodule
